>>> rtl/core/spq_pkg.sv
package spq_pkg;

   localparam int AGE_W  = 8;
   localparam int PRI_W  = 3;
   localparam int ID_W   = 8;
   localparam int SIZE_W = 5;

   typedef enum logic [1:0] {
      REQ_ADD    = 2'd0,
      REQ_POP    = 2'd1,
      REQ_UPDATE = 2'd2,
      REQ_QUERY  = 2'd3
   } spq_req_type;

   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_EMPTY     = 3'd1,
      STAT_FULL      = 3'd2,
      STAT_NOT_FOUND = 3'd3,
      STAT_UNCHANGED = 3'd4
   } spq_status_type;

   typedef enum logic [1:0] {
      COND_NORMAL   = 2'd0,
      COND_URGENT   = 2'd1,
      COND_CRITICAL = 2'd2
   } spq_cond_type;

   localparam logic [PRI_W-1:0] PRI_CRITICAL = 3'd3;
   localparam logic [PRI_W-1:0] PRI_URGENT   = 3'd2;

   typedef enum logic [2:0] {
      FSM_IDLE  = 3'b001,
      FSM_MOVE  = 3'b010,
      FSM_PLACE = 3'b100
   } spq_fsm_type;

   typedef enum logic [2:0] {
      CELL_HOLD   = 3'd0,
      CELL_INSERT = 3'd1,
      CELL_POP    = 3'd2,
      CELL_FIND   = 3'd3,
      CELL_REMOVE = 3'd4
   } spq_cell_op_type;

   // command broadcast to every cell of the row
   typedef struct packed {
      spq_cell_op_type   op;
      logic [PRI_W-1:0]  pri;
      logic [AGE_W-1:0]  age;
   } spq_cmd_type;

   function automatic spq_cond_type cond_of(input logic [PRI_W-1:0] pri);
      spq_cond_type c;
      c = COND_NORMAL;
      if (pri == PRI_CRITICAL) begin
         c = COND_CRITICAL;
      end else if (pri == PRI_URGENT) begin
         c = COND_URGENT;
      end
      return c;
   endfunction

endpackage

>>> rtl/core/stable_priority_queue.sv
// channel  | dir | fields (tuser / tdata, lowest bit first)
// req_     | in  | tuser: req_type[1:0]
//          |     | tdata: patient_id[7:0] age[15:8] priority_req[18:16], zero pad to 24
// rsp_     | out | tuser: status[2:0]
//          |     | tdata: out_id[7:0] out_age[15:8] out_priority[18:16]
//          |     |        out_condition[20:19] queue_size[25:21] front_valid[26]
//          |     |        front_id[34:27], zero pad to 40
//
// Add, pop and query finish from the idle state; update steps through find, remove
// and place, and ends at the remove step, with no removal, when the id is missing or
// the priority is unchanged. The row of DEPTH cells shifts all entries in parallel.
// A new beat is taken once the FSM is idle and the response register is free or
// draining. Reset clears the entry count, FSM and response valid; slot contents
// are left as they are. A stalled response holds until taken.
module stable_priority_queue
   import spq_pkg::*;
#(
   parameter int DEPTH   = 16,
   parameter int ID_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // patient_id, age, priority_req
   input  logic [1:0]  req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // out_id, out_age, out_priority, out_condition,
                                    // queue_size, front_valid, front_id
   output logic [2:0]  rsp_tuser    // status
);

   localparam int IdW  = (ID_BITS < ID_W) ? ID_BITS : ID_W;
   localparam int CntW = $clog2(DEPTH + 1);

   spq_fsm_type      state_ff, state_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic [IdW-1:0]   op_id_ff, op_id_in;
   logic [AGE_W-1:0] op_age_ff, op_age_in;
   logic [PRI_W-1:0] op_pri_ff, op_pri_in;

   logic                rsp_valid_ff, rsp_valid_in;
   spq_status_type      rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [AGE_W-1:0]    rsp_age_ff, rsp_age_in;
   logic [PRI_W-1:0]    rsp_pri_ff, rsp_pri_in;
   spq_cond_type        rsp_cond_ff, rsp_cond_in;
   logic [SIZE_W-1:0]   rsp_size_ff, rsp_size_in;
   logic                rsp_fvalid_ff, rsp_fvalid_in;
   logic [ID_W-1:0]     rsp_fid_ff, rsp_fid_in;
   logic                rsp_load;

   spq_cmd_type      cmd;
   logic [IdW-1:0]   cmd_id;

   logic [IdW-1:0]   cell_id      [DEPTH];
   logic [AGE_W-1:0] cell_age     [DEPTH];
   logic [PRI_W-1:0] cell_pri     [DEPTH];
   logic [IdW-1:0]   cell_id_next [DEPTH];
   logic [DEPTH-1:0] cell_keep;
   logic [DEPTH-1:0] cell_found;
   logic [DEPTH-1:0] cell_after;
   logic [DEPTH-1:0] cell_hit;

   logic             accept;
   spq_req_type      req_kind;
   logic [IdW-1:0]   req_id;
   logic [AGE_W-1:0] req_age;
   logic [PRI_W-1:0] req_pri;
   logic             full;
   logic             empty;

   logic             ex_found;
   logic [IdW-1:0]   ex_id;
   logic [AGE_W-1:0] ex_age;
   logic [PRI_W-1:0] ex_pri;

   assign req_kind = spq_req_type'(req_tuser);
   assign req_id   = IdW'(req_tdata[7:0]);
   assign req_age  = req_tdata[15:8];
   assign req_pri  = req_tdata[18:16];
   assign full     = count_ff == CntW'(DEPTH);
   assign empty    = count_ff == '0;

   assign req_tready = (state_ff == FSM_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   // row of cells, index 0 is the front
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [IdW-1:0]   l_id, r_id;
      logic [AGE_W-1:0] l_age, r_age;
      logic [PRI_W-1:0] l_pri, r_pri;
      logic             l_keep, l_found, l_after;

      if (i == 0) begin : g_front
         assign l_id    = '0;
         assign l_age   = '0;
         assign l_pri   = '0;
         assign l_keep  = 1'b1;
         assign l_found = 1'b0;
         assign l_after = 1'b0;
      end else begin : g_mid
         assign l_id    = cell_id[i-1];
         assign l_age   = cell_age[i-1];
         assign l_pri   = cell_pri[i-1];
         assign l_keep  = cell_keep[i-1];
         assign l_found = cell_found[i-1];
         assign l_after = cell_after[i-1];
      end

      if (i == DEPTH - 1) begin : g_back
         assign r_id  = '0;
         assign r_age = '0;
         assign r_pri = '0;
      end else begin : g_inner
         assign r_id  = cell_id[i+1];
         assign r_age = cell_age[i+1];
         assign r_pri = cell_pri[i+1];
      end

      spq_cell #(
         .ID_BITS (IdW),
         .CNT_W   (CntW),
         .INDEX   (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .cmd_id     (cmd_id),
         .count      (count_ff),
         .left_id    (l_id),
         .left_age   (l_age),
         .left_pri   (l_pri),
         .left_keep  (l_keep),
         .left_found (l_found),
         .left_after (l_after),
         .right_id   (r_id),
         .right_age  (r_age),
         .right_pri  (r_pri),
         .id         (cell_id[i]),
         .age        (cell_age[i]),
         .pri        (cell_pri[i]),
         .id_next    (cell_id_next[i]),
         .keep       (cell_keep[i]),
         .found      (cell_found[i]),
         .after      (cell_after[i]),
         .hit        (cell_hit[i])
      );
   end

   // pull out the entry marked by the last find; at most one cell hits
   always_comb begin
      ex_id  = '0;
      ex_age = '0;
      ex_pri = '0;
      for (int i = 0; i < DEPTH; i++) begin
         ex_id  = ex_id  | (cell_hit[i] ? cell_id[i]  : '0);
         ex_age = ex_age | (cell_age[i] & {AGE_W{cell_hit[i]}});
         ex_pri = ex_pri | (cell_pri[i] & {PRI_W{cell_hit[i]}});
      end
      ex_found = |cell_hit;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      op_id_in      = op_id_ff;
      op_age_in     = op_age_ff;
      op_pri_in     = op_pri_ff;
      cmd.op        = CELL_HOLD;
      cmd.pri       = '0;
      cmd.age       = '0;
      cmd_id        = '0;
      rsp_load      = 1'b0;
      rsp_status_in = STAT_OK;
      rsp_id_in     = '0;
      rsp_age_in    = '0;
      rsp_pri_in    = '0;
      rsp_cond_in   = COND_NORMAL;
      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               case (req_kind)
                  REQ_ADD: begin
                     rsp_load = 1'b1;
                     if (full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        cmd.op      = CELL_INSERT;
                        cmd.pri     = req_pri;
                        cmd.age     = req_age;
                        cmd_id      = req_id;
                        count_in    = count_ff + 1'b1;
                        rsp_id_in   = ID_W'(req_id);
                        rsp_age_in  = req_age;
                        rsp_pri_in  = req_pri;
                        rsp_cond_in = cond_of(req_pri);
                     end
                  end
                  REQ_POP: begin
                     rsp_load = 1'b1;
                     if (empty) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        cmd.op      = CELL_POP;
                        count_in    = count_ff - 1'b1;
                        rsp_id_in   = ID_W'(cell_id[0]);
                        rsp_age_in  = cell_age[0];
                        rsp_pri_in  = cell_pri[0];
                        rsp_cond_in = cond_of(cell_pri[0]);
                     end
                  end
                  REQ_UPDATE: begin
                     cmd.op    = CELL_FIND;
                     cmd_id    = req_id;
                     op_id_in  = req_id;
                     op_pri_in = req_pri;
                     state_in  = FSM_MOVE;
                  end
                  REQ_QUERY: begin
                     rsp_load = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         FSM_MOVE: begin
            if (!ex_found) begin
               rsp_load      = 1'b1;
               rsp_status_in = STAT_NOT_FOUND;
               state_in      = FSM_IDLE;
            end else if (ex_pri == op_pri_ff) begin
               rsp_load      = 1'b1;
               rsp_status_in = STAT_UNCHANGED;
               rsp_id_in     = ID_W'(ex_id);
               rsp_age_in    = ex_age;
               rsp_pri_in    = op_pri_ff;
               rsp_cond_in   = cond_of(op_pri_ff);
               state_in      = FSM_IDLE;
            end else begin
               // drop the entry from the row, reinsert it next cycle
               cmd.op    = CELL_REMOVE;
               count_in  = count_ff - 1'b1;
               op_age_in = ex_age;
               state_in  = FSM_PLACE;
            end
         end
         FSM_PLACE: begin
            cmd.op      = CELL_INSERT;
            cmd.pri     = op_pri_ff;
            cmd.age     = op_age_ff;
            cmd_id      = op_id_ff;
            count_in    = count_ff + 1'b1;
            rsp_load    = 1'b1;
            rsp_id_in   = ID_W'(op_id_ff);
            rsp_age_in  = op_age_ff;
            rsp_pri_in  = op_pri_ff;
            rsp_cond_in = cond_of(op_pri_ff);
            state_in    = FSM_IDLE;
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   assign rsp_size_in   = SIZE_W'(count_in);
   assign rsp_fvalid_in = count_in != '0;
   assign rsp_fid_in    = rsp_fvalid_in ? ID_W'(cell_id_next[0]) : '0;
   assign rsp_valid_in  = rsp_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_id_ff  <= op_id_in;
      op_age_ff <= op_age_in;
      op_pri_ff <= op_pri_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_age_ff    <= rsp_age_in;
         rsp_pri_ff    <= rsp_pri_in;
         rsp_cond_ff   <= rsp_cond_in;
         rsp_size_ff   <= rsp_size_in;
         rsp_fvalid_ff <= rsp_fvalid_in;
         rsp_fid_ff    <= rsp_fid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {5'b0, rsp_fid_ff, rsp_fvalid_ff, rsp_size_ff, rsp_cond_ff,
                        rsp_pri_ff, rsp_age_ff, rsp_id_ff};

endmodule

>>> rtl/core/spq_cell.sv
module spq_cell
   import spq_pkg::*;
#(
   parameter int ID_BITS = 8,
   parameter int CNT_W   = 5,
   parameter int INDEX   = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  spq_cmd_type        cmd,
   input  logic [ID_BITS-1:0] cmd_id,
   input  logic [CNT_W-1:0]   count,
   // neighbor toward the front
   input  logic [ID_BITS-1:0] left_id,
   input  logic [AGE_W-1:0]   left_age,
   input  logic [PRI_W-1:0]   left_pri,
   input  logic               left_keep,
   input  logic               left_found,
   input  logic               left_after,
   // neighbor toward the back
   input  logic [ID_BITS-1:0] right_id,
   input  logic [AGE_W-1:0]   right_age,
   input  logic [PRI_W-1:0]   right_pri,
   output logic [ID_BITS-1:0] id,
   output logic [AGE_W-1:0]   age,
   output logic [PRI_W-1:0]   pri,
   output logic [ID_BITS-1:0] id_next,
   output logic               keep,
   output logic               found,
   output logic               after,
   output logic               hit
);

   logic [ID_BITS-1:0] id_ff, id_in;
   logic [AGE_W-1:0]   age_ff, age_in;
   logic [PRI_W-1:0]   pri_ff, pri_in;
   logic               after_ff, after_in;
   logic               valid;
   logic               match;

   assign valid = count > CNT_W'(INDEX);
   assign keep  = valid && (pri_ff >= cmd.pri);
   assign match = valid && (id_ff == cmd_id);
   assign found = left_found || match;
   assign after = after_ff;
   // first matching cell: marked itself, neighbor in front did not
   assign hit   = after_ff && !left_after;

   always_comb begin
      id_in    = id_ff;
      age_in   = age_ff;
      pri_in   = pri_ff;
      after_in = after_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (!keep) begin
               if (left_keep) begin
                  id_in  = cmd_id;
                  age_in = cmd.age;
                  pri_in = cmd.pri;
               end else begin
                  id_in  = left_id;
                  age_in = left_age;
                  pri_in = left_pri;
               end
            end
         end
         CELL_POP: begin
            id_in  = right_id;
            age_in = right_age;
            pri_in = right_pri;
         end
         CELL_FIND: begin
            after_in = found;
         end
         CELL_REMOVE: begin
            if (after_ff) begin
               id_in  = right_id;
               age_in = right_age;
               pri_in = right_pri;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      id_ff  <= id_in;
      age_ff <= age_in;
      pri_ff <= pri_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         after_ff <= 1'b0;
      end else begin
         after_ff <= after_in;
      end
   end

   assign id      = id_ff;
   assign age     = age_ff;
   assign pri     = pri_ff;
   assign id_next = id_in;

endmodule

>>> rtl/core/spq_checker.sv
module spq_checker
   import spq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   logic [SIZE_W-1:0] size;
   logic              fvalid;
   logic              no_entry;

   assign size     = rsp_tdata[25:21];
   assign fvalid   = rsp_tdata[26];
   assign no_entry = (rsp_tdata[20:0] == '0);

   // hold a stalled response beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response beat changed while stalled");

   // a request is taken only when the response slot is free or draining
   a_req_slot: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> !rsp_tvalid || rsp_tready)
      else $error("request taken while response stalled");

   a_front_size: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (DEPTH < 32) |-> fvalid == (size != '0))
      else $error("front_valid disagrees with queue_size");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STAT_EMPTY |-> size == '0 && !fvalid && no_entry)
      else $error("empty status with entries");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STAT_FULL || rsp_tuser == STAT_NOT_FOUND) |-> no_entry)
      else $error("failed request reports an entry");

endmodule

bind stable_priority_queue spq_checker #(
   .DEPTH (DEPTH)
) u_spq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
